// ===== hdl/fldc_pkg.sv =====
// ----------------------------------------------------------------------------
// fldc_pkg: shared types and constants of the frame latency delay controller
// Word formats, opcodes, register indexes, controller states and fixed values.
// ----------------------------------------------------------------------------
package fldc_pkg;

  localparam int unsigned TARGET_W   = 30;
  localparam int unsigned LIMIT_W    = 30;
  localparam int unsigned INTERVAL_W = 34;
  localparam int unsigned CFG_W      = 34;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [TARGET_W-1:0]   TARGET_RST   = 30'd4000000;
  localparam logic [LIMIT_W-1:0]    LIMIT_RST    = 30'd100000000;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 34'd1000000000;

  // max-FPS period divider: 1e9 / max_fps, one quotient bit per cycle
  localparam int unsigned DIV_BITS = 30;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_BITS + 1);
  localparam logic [DIV_BITS-1:0] FPS_PERIOD_NS = 30'd1000000000;

  localparam logic [62:0] MAX63 = {63{1'b1}};

  typedef enum logic [1:0] {
    OP_EVAL  = 2'd0,
    OP_BEGIN = 2'd1,
    OP_CALIB = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_DELAY   = 2'd0,
    CFG_WAIT_LIMIT     = 2'd1,
    CFG_RECAL_INTERVAL = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [47:0] min_start_dly;
    logic [62:0] now_ns;
    logic [62:0] last_start_ns;
    logic [15:0] max_fps;
    logic [62:0] gpu_ns;
  } in_word_t;

  typedef struct packed {
    logic [29:0]        wait_ns;
    logic [62:0]        deadline_ns;
    logic               recalibrate;
    logic signed [63:0] clock_offset_out;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EVAL,
    ST_SUM,
    ST_LIMIT,
    ST_DEAD,
    ST_DIVW,
    ST_CAP,
    ST_CMP,
    ST_CALIB,
    ST_CALIB2,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load_in;
    logic eval;
    logic sum;
    logic limit;
    logic dead;
    logic cap;
    logic cmp;
    logic calib;
    logic calib2;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_t  opcode;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/frame_latency_delay_controller.sv =====
// ----------------------------------------------------------------------------
// frame_latency_delay_controller: frame-pacing delay regulator
// Adapts a per-frame wait from GPU start delays and tracks the CPU/GPU offset.
// ----------------------------------------------------------------------------
// Words are handled one at a time. An evaluated frame is decoded, evaluated
// and returns no result. A frame begin steps through decode, sum, limit,
// deadline, the wait on the bit-serial divider that forms the max-FPS period
// (30 quotient bits, one per cycle), cap, compare and output load. A
// calibration sample steps through decode, calib, calib2 and output load. A
// finished result sits in the output register; the next word is taken once
// the sequencer is idle, even while that result waits for the receiver. A
// later result holds in its last step until the output register is free.
module frame_latency_delay_controller
  import fldc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word
);

  cmd_t cmd;
  sts_t sts;

  fldc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fldc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== hdl/fldc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fldc_ctrl: sequencer of the frame latency delay controller
// Steps one word at a time through evaluate, frame begin or calibration.
// ----------------------------------------------------------------------------
module fldc_ctrl
  import fldc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts.opcode)
          OP_EVAL:  state_nxt = ST_EVAL;
          OP_BEGIN: state_nxt = ST_SUM;
          OP_CALIB: state_nxt = ST_CALIB;
          OP_NONE:  state_nxt = ST_IDLE;
        endcase
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_LIMIT;
      end
      ST_LIMIT: begin
        cmd.limit = 1'b1;
        state_nxt = ST_DEAD;
      end
      ST_DEAD: begin
        cmd.dead  = 1'b1;
        state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        if (sts.div_done) begin
          state_nxt = ST_CAP;
        end
      end
      ST_CAP: begin
        cmd.cap   = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_CALIB: begin
        cmd.calib = 1'b1;
        state_nxt = ST_CALIB2;
      end
      ST_CALIB2: begin
        cmd.calib2 = 1'b1;
        state_nxt  = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/fldc_dp.sv =====
// ----------------------------------------------------------------------------
// fldc_dp: datapath of the frame latency delay controller
// Config and pacing state, FPS period divider, result and output registers.
// ----------------------------------------------------------------------------
module fldc_dp
  import fldc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word,
  input  cmd_t                 cmd,
  output sts_t                 sts
);

  localparam logic signed [63:0] MAX_S64 = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] MIN_S64 = {1'b1, 63'd0};

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) begin
      return MAX_S64;
    end else if (a[63] && b[63] && !s[63]) begin
      return MIN_S64;
    end
    return s;
  endfunction

  // signed divide by 2^k, truncating toward zero
  function automatic logic signed [63:0] sdiv_pow2(input logic signed [63:0] x,
                                                   input int unsigned k);
    logic signed [63:0] bias;
    bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (x + bias) >>> k;
  endfunction

  logic [TARGET_W-1:0]   target_r;
  logic [LIMIT_W-1:0]    limit_r;
  logic [INTERVAL_W-1:0] interval_r;

  logic signed [63:0] base_r, prev_r, pend_r, offset_r;
  logic [63:0]        recal_at_r;
  logic               calibrated_r;
  logic               out_valid_r;

  in_word_t           in_r;
  logic signed [63:0] imposed_r;
  logic [63:0]        fresh_r;
  logic [29:0]        wait_r;
  logic [62:0]        dead_r;
  logic               recal_r;
  out_word_t          out_r;

  logic [DIV_CNT_W-1:0] cnt_r;
  logic [15:0]          rem_r;
  logic [DIV_BITS-1:0]  dvd_r;

  // evaluated frame
  logic signed [63:0] diff, base_half, nb, nb_floor, pend_else;
  logic               shrink;

  always_comb begin
    diff      = $signed({16'd0, in_r.min_start_dly}) - $signed({34'd0, target_r});
    shrink    = (in_r.min_start_dly < 48'(target_r >> 1)) &&
                (prev_r[63] || prev_r == 64'sd0);
    base_half = sdiv_pow2(base_r, 1);
    nb        = sat_add64(base_r, sdiv_pow2(diff, 5));
    nb_floor  = nb[63] ? 64'sd0 : nb;
    pend_else = sdiv_pow2(diff, 1) - sdiv_pow2(prev_r, 2);
  end

  // frame begin
  logic        over;
  logic [63:0] dsum, csum;
  logic [62:0] cap_sat;

  always_comb begin
    over    = imposed_r > $signed({34'd0, limit_r});
    dsum    = {1'b0, in_r.now_ns} + {34'd0, wait_r};
    csum    = {1'b0, in_r.last_start_ns} + {34'd0, dvd_r};
    cap_sat = csum[63] ? MAX63 : csum[62:0];
  end

  // calibration
  logic signed [63:0] offset_nxt;

  always_comb begin
    if (!calibrated_r) begin
      offset_nxt = $signed(fresh_r);
    end else if ($signed(fresh_r) >= offset_r) begin
      offset_nxt = offset_r + $signed((fresh_r - offset_r) >> 3);
    end else begin
      offset_nxt = offset_r - $signed((offset_r - fresh_r) >> 3);
    end
  end

  // divider step
  logic [16:0] rem_sh;
  logic        ge;

  always_comb begin
    rem_sh = {rem_r, dvd_r[DIV_BITS-1]};
    ge     = rem_sh >= {1'b0, in_r.max_fps};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r     <= TARGET_RST;
      limit_r      <= LIMIT_RST;
      interval_r   <= INTERVAL_RST;
      base_r       <= '0;
      prev_r       <= '0;
      pend_r       <= '0;
      offset_r     <= '0;
      recal_at_r   <= '0;
      calibrated_r <= 1'b0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_TARGET_DELAY:   target_r   <= cfg_wdata[TARGET_W-1:0];
          CFG_WAIT_LIMIT:     limit_r    <= cfg_wdata[LIMIT_W-1:0];
          CFG_RECAL_INTERVAL: interval_r <= cfg_wdata[INTERVAL_W-1:0];
          default: ;
        endcase
      end
      if (cmd.eval) begin
        if (shrink) begin
          base_r <= base_half;
          pend_r <= -base_half;
        end else begin
          base_r <= nb_floor;
          pend_r <= pend_else;
        end
      end
      if (cmd.limit) begin
        pend_r <= '0;
        prev_r <= over ? 64'sd0 : pend_r;
        if (over) begin
          base_r <= '0;
        end
      end
      if (cmd.calib) begin
        recal_at_r <= {1'b0, in_r.now_ns} + {30'd0, interval_r};
      end
      if (cmd.calib2) begin
        offset_r     <= offset_nxt;
        calibrated_r <= 1'b1;
      end
      if (cmd.sum) begin
        cnt_r <= DIV_CNT_W'(DIV_BITS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_word;
    end
    if (cmd.sum) begin
      imposed_r <= sat_add64(base_r, pend_r);
      rem_r     <= '0;
      dvd_r     <= FPS_PERIOD_NS;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? 16'(rem_sh - {1'b0, in_r.max_fps}) : rem_sh[15:0];
      dvd_r <= {dvd_r[DIV_BITS-2:0], ge};
    end
    if (cmd.limit) begin
      recal_r <= over;
      wait_r  <= (over || imposed_r[63]) ? 30'd0 : imposed_r[29:0];
    end
    if (cmd.dead) begin
      dead_r <= dsum[63] ? MAX63 : dsum[62:0];
    end
    if (cmd.cap) begin
      if (in_r.max_fps != 16'd0 && cap_sat > dead_r) begin
        dead_r <= cap_sat;
      end
    end
    if (cmd.cmp) begin
      if ({1'b0, dead_r} > recal_at_r) begin
        recal_r <= 1'b1;
      end
    end
    if (cmd.calib) begin
      fresh_r <= {1'b0, in_r.now_ns} - {1'b0, in_r.gpu_ns};
      wait_r  <= '0;
      dead_r  <= '0;
      recal_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_r.wait_ns          <= wait_r;
      out_r.deadline_ns      <= dead_r;
      out_r.recalibrate      <= recal_r;
      out_r.clock_offset_out <= offset_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_word     = out_r;
  assign sts.opcode   = op_t'(in_r.opcode);
  assign sts.div_done = (cnt_r == '0);
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the frame latency delay controller
// Drives evaluated frames, frame begins and calibration samples through the
// input channel under several register settings. A local copy of the pacing
// rules (base delay, adaptation, wait, deadline, clock offset) predicts each
// result word no directed row sets; all are compared field by field on exit.
// Both channels idle and stall at random, with one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import fldc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 50;
  localparam int unsigned PHASE_WORDS = 250;
  localparam int unsigned HOLD_CYCLES = 400;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  in_word_t             in_word;
  logic                 out_valid;
  logic                 out_stall;
  out_word_t            out_word;

  frame_latency_delay_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // pacing state mirror
  logic [TARGET_W-1:0]   m_target;
  logic [LIMIT_W-1:0]    m_limit;
  logic [INTERVAL_W-1:0] m_interval;
  longint                base_dly;
  longint                prev_adapt;
  longint                pend_adapt;
  logic [63:0]           clk_offset;
  logic [63:0]           recal_at;
  bit                    synced;

  out_word_t   pacing_results_q[$];
  int unsigned n_err;
  int unsigned n_results;
  int unsigned n_cycles;
  bit          no_gaps;

  // traffic generator state
  logic [62:0] t_now;
  logic [63:0] skew;

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t res;
  } stim_row_t;

  stim_row_t stim_table[$];

  function automatic longint sat_sum(longint a, longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63])
      return a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    return s;
  endfunction

  function automatic logic [63:0] sum63(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > {1'b0, MAX63}) ? {1'b0, MAX63} : s;
  endfunction

  function automatic bit pacing_predict(input in_word_t w, output out_word_t r);
    longint      md;
    longint      tgt;
    longint      diff;
    longint      nb;
    longint      imposed;
    logic [63:0] wait64;
    logic [63:0] dl;
    logic [63:0] cap;
    logic [63:0] fresh;
    bit          recal;
    r = '0;
    case (w.opcode)
      OP_EVAL: begin
        md  = longint'({16'b0, w.min_start_dly});
        tgt = longint'({34'b0, m_target});
        if (md < tgt / 2 && prev_adapt <= 0) begin
          base_dly   = base_dly / 2;
          pend_adapt = -base_dly;
        end else begin
          diff       = md - tgt;
          nb         = sat_sum(base_dly, diff / 32);
          base_dly   = (nb < 0) ? 0 : nb;
          pend_adapt = diff / 2 - prev_adapt / 4;
        end
        return 1'b0;
      end
      OP_BEGIN: begin
        recal      = 1'b0;
        imposed    = sat_sum(base_dly, pend_adapt);
        prev_adapt = pend_adapt;
        pend_adapt = 0;
        if (imposed > longint'({34'b0, m_limit})) begin
          recal      = 1'b1;
          base_dly   = 0;
          prev_adapt = 0;
          imposed    = 0;
        end
        wait64 = (imposed < 0) ? 64'd0 : 64'(imposed);
        dl = sum63({1'b0, w.now_ns}, wait64);
        if (w.max_fps != 16'd0) begin
          cap = sum63({1'b0, w.last_start_ns}, 64'd1000000000 / {48'b0, w.max_fps});
          if (cap > dl)
            dl = cap;
        end
        if (dl > recal_at)
          recal = 1'b1;
        r.wait_ns          = wait64[29:0];
        r.deadline_ns      = dl[62:0];
        r.recalibrate      = recal;
        r.clock_offset_out = clk_offset;
        return 1'b1;
      end
      OP_CALIB: begin
        fresh = {1'b0, w.now_ns} - {1'b0, w.gpu_ns};
        if (!synced) begin
          clk_offset = fresh;
          synced     = 1'b1;
        end else if ($signed(fresh) >= $signed(clk_offset)) begin
          clk_offset = clk_offset + (fresh - clk_offset) / 64'd8;
        end else begin
          clk_offset = clk_offset - (clk_offset - fresh) / 64'd8;
        end
        recal_at = {1'b0, w.now_ns} + {30'b0, m_interval};
        r.clock_offset_out = clk_offset;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [63:0] rnd_bits(int unsigned n);
    logic [63:0] v;
    logic [63:0] m;
    m = {64{1'b1}} >> (64 - n);
    v = {$urandom, $urandom};
    if ($urandom_range(0, 19) != 0)
      v = v >> $urandom_range(0, n - 1);
    return v & m;
  endfunction

  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 96)
      return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic in_word_t noise_word();
    in_word_t w;
    w.opcode        = 2'($urandom_range(0, 3));
    w.min_start_dly = 48'(rnd_bits(48));
    w.now_ns        = 63'(rnd_bits(63));
    w.last_start_ns = 63'(rnd_bits(63));
    w.max_fps       = 16'(rnd_bits(16));
    w.gpu_ns        = 63'(rnd_bits(63));
    return w;
  endfunction

  // plausible word of a running frame loop; a frame begin advances the frame clock
  function automatic in_word_t frame_word(op_t op);
    in_word_t    w;
    int unsigned c;
    int unsigned d;
    logic [63:0] g;
    w        = noise_word();
    w.opcode = op;
    case (op)
      OP_EVAL: begin
        c = $urandom_range(0, 99);
        if (c < 30)
          w.min_start_dly = 48'($urandom_range(0, 32'(m_target) / 2));
        else if (c < 75)
          w.min_start_dly = 48'(32'(m_target) - 32'(m_target) / 4
                                + $urandom_range(0, 32'(m_target) / 2));
        else if (c < 92)
          w.min_start_dly = 48'($urandom_range(0, 32'(m_target) * 4));
      end
      OP_BEGIN: begin
        t_now = t_now + 63'(1000000 + $urandom_range(0, 30000000));
        d = $urandom_range(0, 40000000);
        w.now_ns = t_now;
        w.last_start_ns = (t_now > 63'(d)) ? t_now - 63'(d) : 63'd0;
        case ($urandom_range(0, 7))
          0: w.max_fps = 16'd0;
          1: w.max_fps = 16'd30;
          2: w.max_fps = 16'd60;
          3: w.max_fps = 16'd144;
          4: w.max_fps = 16'd1;
          5: w.max_fps = 16'hFFFF;
          default: w.max_fps = 16'($urandom_range(0, 65535));
        endcase
      end
      default: begin
        w.now_ns = t_now + 63'($urandom_range(0, 1000000));
        g = {1'b0, w.now_ns} - skew + 64'($urandom_range(0, 20000));
        w.gpu_ns = g[62:0];
      end
    endcase
    return w;
  endfunction

  task automatic add_row(op_t op, logic [47:0] md, logic [62:0] now, logic [62:0] last,
                         logic [15:0] fps, logic [62:0] gpu, bit typed, out_word_t res);
    stim_row_t row;
    row.w.opcode        = op;
    row.w.min_start_dly = md;
    row.w.now_ns        = now;
    row.w.last_start_ns = last;
    row.w.max_fps       = fps;
    row.w.gpu_ns        = gpu;
    row.typed           = typed;
    row.res             = res;
    stim_table.push_back(row);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_TARGET_DELAY:   m_target   = v[TARGET_W-1:0];
      CFG_WAIT_LIMIT:     m_limit    = v[LIMIT_W-1:0];
      CFG_RECAL_INTERVAL: m_interval = v[INTERVAL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_word(in_word_t w, bit typed, out_word_t res);
    int unsigned gap;
    out_word_t   r;
    gap = no_gaps ? 0 : pick_idle();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    if (pacing_predict(w, r))
      pacing_results_q.push_back(typed ? res : r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pacing_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pacing_results_q.size() == 0) begin
        n_err++;
        $display("%0t: unexpected result word %h", $time, out_word);
      end else begin
        e = pacing_results_q.pop_front();
        if (out_word.wait_ns !== e.wait_ns) begin
          n_err++;
          $display("%0t: wait_ns expected %0d got %0d", $time, e.wait_ns, out_word.wait_ns);
        end
        if (out_word.deadline_ns !== e.deadline_ns) begin
          n_err++;
          $display("%0t: deadline_ns expected %0d got %0d", $time, e.deadline_ns,
                   out_word.deadline_ns);
        end
        if (out_word.recalibrate !== e.recalibrate) begin
          n_err++;
          $display("%0t: recalibrate expected %0b got %0b", $time, e.recalibrate,
                   out_word.recalibrate);
        end
        if (out_word.clock_offset_out !== e.clock_offset_out) begin
          n_err++;
          $display("%0t: clock_offset_out expected %0d got %0d", $time,
                   e.clock_offset_out, out_word.clock_offset_out);
        end
      end
    end
  end

  // output back-pressure, with one long hold-off once results flow
  initial begin
    int unsigned n;
    bit          held;
    held = 1'b0;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!held && n_results >= 40) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = pick_idle();
        if (n == 0) begin
          out_stall <= 1'b0;
          repeat (($urandom_range(0, 30) == 0) ? 300 : $urandom_range(1, 12)) @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("frame_latency_delay_controller verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned ph;
    int unsigned i;
    int unsigned c;
    in_word_t    w;
    n_err      = 0;
    n_results  = 0;
    n_cycles   = 0;
    no_gaps    = 1'b0;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_TARGET_DELAY;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    m_target   = TARGET_RST;
    m_limit    = LIMIT_RST;
    m_interval = INTERVAL_RST;
    base_dly   = 0;
    prev_adapt = 0;
    pend_adapt = 0;
    clk_offset = '0;
    recal_at   = '0;
    synced     = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words, run at the reset register values
    add_row(OP_BEGIN, '0, '0, '0, '0, '0, 1'b1, '0);
    add_row(OP_CALIB, '0, 63'd1000, '0, '0, 63'd400, 1'b1,
            out_word_t'({30'd0, 63'd0, 1'b0, 64'd600}));
    add_row(OP_NONE, '1, MAX63, MAX63, '1, MAX63, 1'b0, '0);
    add_row(OP_EVAL, '0, '0, '0, '0, '0, 1'b0, '0);
    add_row(OP_EVAL, '1, '0, '0, '0, '0, 1'b0, '0);
    add_row(OP_BEGIN, '0, 63'd5000, '0, 16'd1, '0, 1'b0, '0);
    add_row(OP_EVAL, 48'd8000000, '0, '0, '0, '0, 1'b0, '0);
    add_row(OP_BEGIN, '0, 63'd1000000, 63'd1000000, 16'hFFFF, '0, 1'b0, '0);
    add_row(OP_EVAL, 48'd1000000, '0, '0, '0, '0, 1'b0, '0);
    add_row(OP_BEGIN, '0, 63'd2000000, 63'd1500000, 16'd60, '0, 1'b0, '0);
    add_row(OP_EVAL, '0, '0, '0, '0, '0, 1'b0, '0);
    add_row(OP_EVAL, 48'd2000000, '0, '0, '0, '0, 1'b0, '0);
    add_row(OP_BEGIN, '0, MAX63, MAX63, 16'd1, '0, 1'b0, '0);
    add_row(OP_CALIB, '0, '0, '0, '0, MAX63, 1'b0, '0);
    add_row(OP_CALIB, '0, MAX63, '0, '0, '0, 1'b0, '0);
    add_row(OP_CALIB, '0, MAX63, '0, '0, MAX63, 1'b0, '0);
    add_row(OP_BEGIN, '0, '0, '0, '0, '0, 1'b0, '0);
    add_row(OP_EVAL, 48'd1999999, '0, '0, '0, '0, 1'b0, '0);
    add_row(OP_EVAL, 48'h00FF_FFFF_FFFF, '0, '0, '0, '0, 1'b0, '0);
    add_row(OP_BEGIN, '0, 63'd123, '0, 16'd2, '0, 1'b0, '0);
    add_row(OP_NONE, '0, '0, '0, '0, '0, 1'b0, '0);
    foreach (stim_table[k])
      send_word(stim_table[k].w, stim_table[k].typed, stim_table[k].res);

    for (ph = 0; ph < 6; ph++) begin
      if (ph != 0) begin
        drain();
        case (ph)
          1: begin
            write_reg(CFG_TARGET_DELAY, '0);
            write_reg(CFG_WAIT_LIMIT, '0);
            write_reg(CFG_RECAL_INTERVAL, '0);
          end
          2: begin
            write_reg(CFG_TARGET_DELAY, '1);
            write_reg(CFG_WAIT_LIMIT, '1);
            write_reg(CFG_RECAL_INTERVAL, '1);
            write_reg(CFG_UNUSED, CFG_W'(rnd_bits(CFG_W)));
          end
          3: begin
            write_reg(CFG_TARGET_DELAY, CFG_W'($urandom_range(1000000, 20000000)));
            write_reg(CFG_WAIT_LIMIT, CFG_W'($urandom_range(5000000, 100000000)));
            write_reg(CFG_RECAL_INTERVAL, CFG_W'($urandom_range(10000000, 1000000000)));
          end
          4: begin
            write_reg(CFG_TARGET_DELAY, CFG_W'(rnd_bits(CFG_W)));
            write_reg(CFG_WAIT_LIMIT, CFG_W'(rnd_bits(CFG_W)));
            write_reg(CFG_RECAL_INTERVAL, CFG_W'(rnd_bits(CFG_W)));
          end
          default: begin
            write_reg(CFG_TARGET_DELAY, 34'd1000000000);
            write_reg(CFG_WAIT_LIMIT, 34'd1000000000);
            write_reg(CFG_RECAL_INTERVAL, 34'd10000000000);
          end
        endcase
      end
      t_now = ph[0] ? 63'({$urandom, $urandom} >> 2) : 63'($urandom);
      skew  = 64'({8'($urandom_range(0, 255)), $urandom}) - 64'h80_0000_0000;
      i = 0;
      while (i < PHASE_WORDS) begin
        no_gaps = (i >= 100 && i < 150);
        c = $urandom_range(0, 99);
        if (c < 80) begin
          if ($urandom_range(0, 9) != 0) begin
            send_word(frame_word(OP_EVAL), 1'b0, '0);
            i++;
          end
          send_word(frame_word(OP_BEGIN), 1'b0, '0);
          i++;
          if ($urandom_range(0, 7) == 0) begin
            send_word(frame_word(OP_CALIB), 1'b0, '0);
            i++;
          end
        end else begin
          if (c < 90)
            w = frame_word(op_t'($urandom_range(0, 2)));
          else
            w = noise_word();
          send_word(w, 1'b0, '0);
          if (w.opcode != OP_NONE)
            i++;
        end
      end
      no_gaps = 1'b0;
    end

    drain();
    if (n_err == 0)
      $display("frame_latency_delay_controller verification clean");
    else
      $display("frame_latency_delay_controller verification failed");
    $finish;
  end

endmodule

// ===== frame_latency_delay_controller.f =====
hdl/fldc_pkg.sv
hdl/fldc_ctrl.sv
hdl/fldc_dp.sv
hdl/frame_latency_delay_controller.sv
dv/tb_top.sv
